// ===== sv/hmdu_pkg.sv =====
// Package for the HI/LO multiply-divide unit: operation codes, fault codes, widths.
// No dependencies.
`timescale 1ns / 1ps
package hmdu_pkg;
  localparam int unsigned DataW  = 64;
  localparam int unsigned NumAcc = 4;
  localparam int unsigned AccW   = 2;

  typedef enum logic [3:0] {
    OP_DIV   = 4'd0,
    OP_DIVU  = 4'd1,
    OP_MULT  = 4'd2,
    OP_MULTU = 4'd3,
    OP_MADD  = 4'd4,
    OP_MADDU = 4'd5,
    OP_MSUB  = 4'd6,
    OP_MSUBU = 4'd7,
    OP_DDIV  = 4'd8,
    OP_DDIVU = 4'd9
  } op_e;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_RI   = 2'd1;
  localparam logic [1:0] FAULT_DSP  = 2'd2;

  function automatic logic [DataW-1:0] sx32(input logic [DataW-1:0] v);
    sx32 = {{32{v[31]}}, v[31:0]};
  endfunction
endpackage

// ===== sv/hmdu_req_if.sv =====
// Request channel interface for the HI/LO unit.
// Depends on hmdu_pkg.
`timescale 1ns / 1ps
interface hmdu_req_if;
  logic                     valid;
  logic                     ready;
  logic [3:0]               req_type;
  logic [hmdu_pkg::DataW-1:0] operand_a;
  logic [hmdu_pkg::DataW-1:0] operand_b;
  logic [hmdu_pkg::AccW-1:0]  acc_select;
  modport source (output valid, req_type, operand_a, operand_b, acc_select, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, acc_select, output ready);
endinterface

// ===== sv/hmdu_rsp_if.sv =====
// Result channel interface for the HI/LO unit.
// Depends on hmdu_pkg.
`timescale 1ns / 1ps
interface hmdu_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [hmdu_pkg::DataW-1:0] lo_value;
  logic [hmdu_pkg::DataW-1:0] hi_value;
  logic [1:0]               fault;
  modport source (output valid, lo_value, hi_value, fault, input ready);
  modport sink   (input valid, lo_value, hi_value, fault, output ready);
endinterface

// ===== sv/hilo_multiply_divide_unit_top.sv =====
// HI/LO multiply-divide unit: four accumulator pairs, bit-serial multiply and divide.
// Depends on hmdu_pkg, hmdu_req_if, hmdu_rsp_if.
`timescale 1ns / 1ps
// One request at a time. Faults and divide-by-zero skip the shift steps and
// go from S_RUN straight to S_FIN. 32-bit operations run 32 shift-add or
// shift-subtract steps, 64-bit divides 64 steps, one bit per cycle, then a
// finishing step in S_FIN registers the result. The result sits in an output
// register; the next request is taken only once that beat has gone, so a new
// request always waits until the previous result has been taken.
// A configuration write takes effect on the next request.
module hilo_multiply_divide_unit_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  hmdu_req_if.sink   req,
  hmdu_rsp_if.source rsp
);
  import hmdu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RUN  = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;

  logic [2:0]       state_q, state_d;
  logic             dsp_q;
  logic [DataW-1:0] lo_q [NumAcc];
  logic [DataW-1:0] hi_q [NumAcc];

  logic [3:0]       op_q;
  logic [AccW-1:0]  acc_q;
  logic [6:0]       cnt_q;
  logic [DataW-1:0] a_q;     // dividend / quotient shift, or multiplier shift
  logic [DataW-1:0] b_q;     // divisor magnitude, or multiplicand
  logic [DataW:0]   r_q;     // partial remainder, or product high part
  logic             nq_q, nr_q;  // negate quotient / remainder
  logic             ovf_q, dz_q;
  logic [DataW-1:0] olo_q, ohi_q;
  logic [1:0]       oflt_q;
  logic             ovalid_q;

  logic is_div, is_w64, is_sgn;
  logic [DataW-1:0] xa, xb, ma, mb;
  always_comb begin
    is_div = (req.req_type == OP_DIV) || (req.req_type == OP_DIVU) ||
             (req.req_type == OP_DDIV) || (req.req_type == OP_DDIVU);
    is_w64 = (req.req_type == OP_DDIV) || (req.req_type == OP_DDIVU);
    is_sgn = (req.req_type == OP_DIV) || (req.req_type == OP_DDIV);
    if (is_w64) begin
      xa = req.operand_a; xb = req.operand_b;
    end else if (is_sgn) begin
      xa = sx32(req.operand_a); xb = sx32(req.operand_b);
    end else begin
      xa = {32'd0, req.operand_a[31:0]}; xb = {32'd0, req.operand_b[31:0]};
    end
    ma = (is_sgn && xa[DataW-1]) ? (~xa + 1'b1) : xa;
    mb = (is_sgn && xb[DataW-1]) ? (~xb + 1'b1) : xb;
  end

  logic op_div_q, op_w64_q;
  // divide step
  logic [DataW:0] rs, rsub;
  // multiply step (32-bit): r_q[31:0] holds high product part, a_q lower
  logic [32:0] madd;
  always_comb begin
    rs   = {r_q[DataW-1:0], a_q[DataW-1]};
    rsub = rs - {1'b0, b_q};
    madd = {1'b0, r_q[31:0]} + (a_q[0] ? {1'b0, b_q[31:0]} : 33'd0);
  end

  // finishing
  logic [DataW-1:0] q_f, r_f, p_f, sum_f, res_lo, res_hi;
  logic [DataW-1:0] mul_x;
  always_comb begin
    q_f = nq_q ? (~a_q + 1'b1) : a_q;
    r_f = nr_q ? (~r_q[DataW-1:0] + 1'b1) : r_q[DataW-1:0];
    p_f = {r_q[31:0], a_q[63:32]};
    // a_q[31:0] holds the multiplier again once all its bits have shifted through
    mul_x = b_q;
    if (nq_q) begin
      // signed: subtract y<<32 if x neg, x<<32 if y neg (mod 2^64)
      p_f = p_f - ((b_q[31] ? {a_q[31:0], 32'd0} : 64'd0) +
                   (nr_q ? {b_q[31:0], 32'd0} : 64'd0));
    end
    sum_f = {hi_q[acc_q][31:0], lo_q[acc_q][31:0]};
    if (op_q == OP_MADD || op_q == OP_MADDU) p_f = sum_f + p_f;
    else if (op_q == OP_MSUB || op_q == OP_MSUBU) p_f = sum_f - p_f;
    if (op_div_q) begin
      if (op_w64_q) begin
        res_lo = ovf_q ? mul_x : q_f;
        res_hi = ovf_q ? 64'd0 : r_f;
      end else begin
        res_lo = sx32(ovf_q ? mul_x : q_f);
        res_hi = ovf_q ? 64'd0 : sx32(r_f);
      end
    end else begin
      res_lo = sx32(p_f);
      res_hi = sx32({32'd0, p_f[63:32]});
    end
  end

  assign req.ready    = (state_q == S_IDLE) && !ovalid_q;
  assign rsp.valid    = ovalid_q;
  assign rsp.lo_value = olo_q;
  assign rsp.hi_value = ohi_q;
  assign rsp.fault    = oflt_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (req.valid && req.ready) state_d = S_RUN;
      S_RUN:   if (cnt_q == 7'd0) state_d = S_FIN;
      S_FIN:   state_d = S_IDLE;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic dsp_bad;
  assign dsp_bad = (req.acc_select != '0) && !dsp_q;

  logic ovf_in;
  assign ovf_in = is_sgn && (xb == '1) &&
                  (is_w64 ? (xa == {1'b1, 63'd0}) : (xa == sx32(64'h8000_0000)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      dsp_q    <= 1'b0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < NumAcc; i++) begin
        lo_q[i] <= '0;
        hi_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) dsp_q <= cfg_wdata_i;
      if (rsp.valid && rsp.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            op_q     <= req.req_type;
            acc_q    <= req.acc_select;
            op_div_q <= is_div;
            op_w64_q <= is_w64;
            r_q      <= '0;
            if (req.req_type > OP_DDIVU) begin
              oflt_q <= FAULT_RI; dz_q <= 1'b1; ovf_q <= 1'b0; cnt_q <= '0;
            end else if (is_div) begin
              oflt_q <= FAULT_NONE;
              a_q    <= is_w64 ? ma : {ma[31:0], 32'd0};
              b_q    <= ovf_in ? xa : mb; // dividend kept for overflow result
              nq_q   <= is_sgn && (xa[DataW-1] ^ xb[DataW-1]);
              nr_q   <= is_sgn && xa[DataW-1];
              ovf_q  <= ovf_in;
              dz_q   <= (xb == '0);
              cnt_q  <= (xb == '0) ? 7'd0 : (is_w64 ? 7'd63 : 7'd31);
            end else begin
              ovf_q <= 1'b0;
              if (dsp_bad) begin
                oflt_q <= FAULT_DSP; dz_q <= 1'b1; cnt_q <= '0;
              end else if ({1'b0, req.acc_select} >= (AccW+1)'(NumAcc)) begin
                oflt_q <= FAULT_RI; dz_q <= 1'b1; cnt_q <= '0;
              end else begin
                oflt_q <= FAULT_NONE; dz_q <= 1'b0; cnt_q <= 7'd31;
              end
              a_q   <= {2{req.operand_b[31:0]}};
              b_q   <= {32'd0, req.operand_a[31:0]};
              nq_q  <= !req.req_type[0];
              nr_q  <= !req.req_type[0] && req.operand_b[31];
            end
          end
        end
        S_RUN: begin
          if (!dz_q) begin
            if (op_div_q && !ovf_q) begin
              if (!rsub[DataW]) begin
                r_q <= rsub;
                a_q <= {a_q[DataW-2:0], 1'b1};
              end else begin
                r_q <= rs;
                a_q <= {a_q[DataW-2:0], 1'b0};
              end
            end else if (!op_div_q) begin
              r_q[31:0] <= madd[32:1];
              a_q       <= {madd[0], a_q[DataW-1:1]};
            end
          end
          if (cnt_q != 7'd0) cnt_q <= cnt_q - 7'd1;
        end
        S_FIN: begin
          ovalid_q <= 1'b1;
          if (oflt_q != FAULT_NONE) begin
            olo_q <= '0; ohi_q <= '0;
          end else if (dz_q) begin
            olo_q <= lo_q[0]; ohi_q <= hi_q[0];
          end else if (op_div_q) begin
            lo_q[0] <= res_lo; hi_q[0] <= res_hi;
            olo_q <= res_lo; ohi_q <= res_hi;
          end else begin
            lo_q[acc_q] <= res_lo; hi_q[acc_q] <= res_hi;
            olo_q <= res_lo; ohi_q <= res_hi;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
